[sv/tsw_pkg.sv]
// ----------------------------------------------------------------------------
// tsw_pkg
// Types and constants shared by the TCP sender window/retransmit block.
// ----------------------------------------------------------------------------
`default_nettype none
package tsw_pkg;

	localparam int MAX_RESULTS = 48;
	localparam int NW          = 6;

	localparam logic [1:0] OP_FILL = 2'd0;
	localparam logic [1:0] OP_ACK  = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic REG_ISN     = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;

	typedef struct packed {
		logic        has;
		logic [31:0] seqno;
		logic [10:0] len;
		logic        syn;
		logic        fin;
		logic        retx;
		logic        acc;
		logic [16:0] flight;
		logic [7:0]  rcnt;
		logic        last;
	} res_t;

	typedef struct packed {
		logic latch;
		logic syn_send;
		logic probe;
		logic fill_room;
		logic fill_send;
		logic u_load;
		logic u_add;
		logic u_sub;
		logic ack_win;
		logic ack_adv;
		logic ack_pop;
		logic ack_end;
		logic tick_add;
		logic tick_fire;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       syn_sent;
		logic       win_zero;
		logic       guard_stop;
		logic       room_zero;
		logic       fill_stop;
		logic       slot_ok;
		logic       out_free;
		logic       c1;
		logic       c2;
		logic       beyond;
		logic       old;
		logic       q_empty;
		logic       pop;
		logic       tact;
		logic       tmo;
	} sts_t;

endpackage
`default_nettype wire

[sv/tsw_ctrl.sv]
// ----------------------------------------------------------------------------
// tsw_ctrl
// Event sequencer: steps fill, ack and tick handling one action per cycle, waiting while the output is not free.
// ----------------------------------------------------------------------------
`default_nettype none
module tsw_ctrl import tsw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  sts_t      sts,
	output cmd_t      cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DISP   = 4'd1;
	localparam logic [3:0] S_FILL_A = 4'd2;
	localparam logic [3:0] S_FILL_B = 4'd3;
	localparam logic [3:0] S_U2     = 4'd4;
	localparam logic [3:0] S_U3     = 4'd5;
	localparam logic [3:0] S_AV     = 4'd6;
	localparam logic [3:0] S_AOLD   = 4'd7;
	localparam logic [3:0] S_ACK_RD = 4'd8;
	localparam logic [3:0] S_ACK_CMP= 4'd9;
	localparam logic [3:0] S_ACK_END= 4'd10;
	localparam logic [3:0] S_TICK2  = 4'd11;
	localparam logic [3:0] S_FINISH = 4'd12;

	logic [3:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				unique case (sts.op)
					OP_FILL: begin
						if (!sts.syn_sent) begin
							cmd.syn_send = 1'b1;
							state_d      = S_FINISH;
						end else if (sts.win_zero) begin
							cmd.probe = 1'b1;
							state_d   = S_FINISH;
						end else begin
							state_d = S_FILL_A;
						end
					end
					OP_ACK: begin
						cmd.u_load = 1'b1;
						state_d    = S_U2;
					end
					OP_TICK: begin
						if (sts.tact) begin
							cmd.tick_add = 1'b1;
							state_d      = S_TICK2;
						end else begin
							state_d = S_FINISH;
						end
					end
					default: state_d = S_FINISH;
				endcase
			end
			S_FILL_A: begin
				if (sts.guard_stop) begin
					state_d = S_FINISH;
				end else begin
					cmd.fill_room = 1'b1;
					state_d       = S_FILL_B;
				end
			end
			S_FILL_B: begin
				if (sts.room_zero || sts.fill_stop) begin
					state_d = S_FINISH;
				end else if (sts.slot_ok) begin
					cmd.fill_send = 1'b1;
					state_d       = S_FILL_A;
				end
			end
			S_U2: begin
				if (sts.c1) begin
					cmd.u_add = 1'b1;
					state_d   = S_AV;
				end else begin
					state_d = S_U3;
				end
			end
			S_U3: begin
				cmd.u_sub = sts.c2;
				state_d   = S_AV;
			end
			S_AV: begin
				if (sts.beyond) begin
					state_d = S_FINISH;
				end else begin
					cmd.ack_win = 1'b1;
					state_d     = S_AOLD;
				end
			end
			S_AOLD: begin
				if (sts.old) begin
					state_d = S_FINISH;
				end else begin
					cmd.ack_adv = 1'b1;
					state_d     = S_ACK_RD;
				end
			end
			S_ACK_RD: state_d = S_ACK_CMP;
			S_ACK_CMP: begin
				if (sts.q_empty || !sts.pop) begin
					state_d = S_ACK_END;
				end else begin
					cmd.ack_pop = 1'b1;
					state_d     = S_ACK_RD;
				end
			end
			S_ACK_END: begin
				cmd.ack_end = 1'b1;
				state_d     = S_FINISH;
			end
			S_TICK2: begin
				cmd.tick_fire = sts.tmo && !sts.q_empty;
				state_d       = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

[sv/tsw_dp.sv]
// ----------------------------------------------------------------------------
// tsw_dp
// Sequence state, outstanding-segment queue, timer and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
module tsw_dp import tsw_pkg::*; #(
	parameter int MAX_SEGMENT_PAYLOAD = 1452,
	parameter int PENDING_DEPTH       = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [1:0]  in_op,
	input  wire logic [31:0] in_ack,
	input  wire logic [15:0] in_win,
	input  wire logic [15:0] in_ms,
	input  wire logic [15:0] in_avail,
	input  wire logic        in_ended,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  wire logic        out_ready,
	output logic             out_valid,
	output res_t             out_res
);

	localparam int AW = $clog2(PENDING_DEPTH);
	localparam int CW = $clog2(PENDING_DEPTH + 1);
	localparam int LW = $clog2(MAX_SEGMENT_PAYLOAD + 1);

	logic [1:0]  op_q;
	logic [31:0] ackno_q;
	logic [15:0] win_in_q, ms_q, avail_q;
	logic        ended_q, acc_q;
	logic [NW-1:0] n_q;
	logic [63:0] next_q, acked_q, cand_q;
	logic [15:0] window_q, ito_q;
	logic [16:0] flight_q, room_q;
	logic        syn_sent_q, fin_sent_q, tact_q;
	logic [31:0] timer_q, to_q, isn_q;
	logic [7:0]  rcnt_q;
	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;
	res_t        held_q, out_q;
	logic        held_v_q, out_v_q;

	logic [63:0]   mem_start [PENDING_DEPTH];
	logic [LW-1:0] mem_len   [PENDING_DEPTH];
	logic          mem_syn   [PENDING_DEPTH];
	logic          mem_fin   [PENDING_DEPTH];
	logic [63:0]   rd_start_q;
	logic [LW-1:0] rd_len_q;
	logic          rd_syn_q, rd_fin_q;

	// fill chunk sizing
	logic [16:0] used, room_c, len_a, len_b, seqlen, rd_seqlen;
	logic [15:0] avail_n;
	logic        fin_b, out_free, full;
	logic [LW-1:0] snd_len;
	logic        snd_syn, snd_fin, do_send;
	logic [32:0] tsum;
	logic [7:0]  rcnt_inc;
	res_t        new_res, probe_res, retx_res, empty_res, fin_res;

	assign used    = next_q[16:0] - acked_q[16:0];
	assign room_c  = ({1'b0, window_q} > used) ? ({1'b0, window_q} - used) : 17'd0;
	assign len_a   = (room_q < {1'b0, avail_q}) ? room_q : {1'b0, avail_q};
	assign len_b   = (len_a > 17'(MAX_SEGMENT_PAYLOAD)) ? 17'(MAX_SEGMENT_PAYLOAD) : len_a;
	assign avail_n = avail_q - len_b[15:0];
	assign fin_b   = ended_q && (avail_n == 16'd0) && (len_b < room_q);

	assign do_send = cmd.syn_send || cmd.fill_send;
	assign snd_syn = cmd.syn_send;
	assign snd_fin = cmd.fill_send && fin_b;
	assign snd_len = cmd.fill_send ? LW'(len_b) : '0;
	assign seqlen  = 17'(snd_len) + {16'd0, snd_syn} + {16'd0, snd_fin};

	assign rd_seqlen = 17'(rd_len_q) + {16'd0, rd_syn_q} + {16'd0, rd_fin_q};
	assign tsum      = {1'b0, timer_q} + {17'd0, ms_q};
	assign rcnt_inc  = (rcnt_q == 8'hFF) ? 8'hFF : rcnt_q + 8'd1;
	assign out_free  = !out_v_q || out_ready;
	assign full      = (count_q == CW'(PENDING_DEPTH));

	always_comb begin
		new_res        = '0;
		new_res.has    = 1'b1;
		new_res.seqno  = next_q[31:0] + isn_q;
		new_res.len    = 11'(snd_len);
		new_res.syn    = snd_syn;
		new_res.fin    = snd_fin;
		new_res.flight = flight_q + seqlen;
		new_res.rcnt   = rcnt_q;

		probe_res        = '0;
		probe_res.has    = 1'b1;
		probe_res.seqno  = next_q[31:0] + isn_q;
		probe_res.flight = flight_q;
		probe_res.rcnt   = rcnt_q;

		retx_res        = '0;
		retx_res.has    = 1'b1;
		retx_res.seqno  = rd_start_q[31:0] + isn_q;
		retx_res.len    = 11'(rd_len_q);
		retx_res.syn    = rd_syn_q;
		retx_res.fin    = rd_fin_q;
		retx_res.retx   = 1'b1;
		retx_res.flight = flight_q;
		retx_res.rcnt   = rcnt_inc;

		empty_res        = '0;
		empty_res.acc    = acc_q;
		empty_res.flight = flight_q;
		empty_res.rcnt   = rcnt_q;
		empty_res.last   = 1'b1;

		fin_res      = held_v_q ? held_q : empty_res;
		fin_res.last = 1'b1;
	end

	always_comb begin
		sts            = '0;
		sts.op         = op_q;
		sts.syn_sent   = syn_sent_q;
		sts.win_zero   = (window_q == 16'd0);
		sts.guard_stop = fin_sent_q || (n_q == NW'(MAX_RESULTS)) || full;
		sts.room_zero  = (room_q == 17'd0);
		sts.fill_stop  = (len_b == 17'd0) && !fin_b;
		sts.slot_ok    = !held_v_q || out_free;
		sts.out_free   = out_free;
		sts.c1         = (cand_q + 64'h8000_0000) < acked_q;
		sts.c2         = (cand_q > (acked_q + 64'h8000_0000)) && (cand_q[63:32] != 32'd0);
		sts.beyond     = cand_q > next_q;
		sts.old        = cand_q <= acked_q;
		sts.q_empty    = (count_q == '0);
		sts.pop        = (rd_start_q + 64'(rd_seqlen)) <= acked_q;
		sts.tact       = tact_q;
		sts.tmo        = timer_q >= to_q;
	end

	// queue store, registered read of the head entry
	always_ff @(posedge clk) begin
		if (do_send) begin
			mem_start[tail_q] <= next_q;
			mem_len[tail_q]   <= snd_len;
			mem_syn[tail_q]   <= snd_syn;
			mem_fin[tail_q]   <= snd_fin;
		end
		rd_start_q <= mem_start[head_q];
		rd_len_q   <= mem_len[head_q];
		rd_syn_q   <= mem_syn[head_q];
		rd_fin_q   <= mem_fin[head_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q     <= in_op;
			ackno_q  <= in_ack;
			win_in_q <= in_win;
			ms_q     <= in_ms;
			avail_q  <= in_avail;
			ended_q  <= in_ended;
		end else if (cmd.fill_send) begin
			avail_q <= avail_n;
		end
		if (cmd.fill_room) room_q <= room_c;
		if (cmd.u_load) begin
			cand_q <= {acked_q[63:32], ackno_q - isn_q};
		end else if (cmd.u_add) begin
			cand_q <= cand_q + 64'h1_0000_0000;
		end else if (cmd.u_sub) begin
			cand_q <= cand_q - 64'h1_0000_0000;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isn_q      <= '0;
			ito_q      <= 16'd1000;
			to_q       <= 32'd1000;
			next_q     <= '0;
			acked_q    <= '0;
			window_q   <= 16'd1;
			flight_q   <= '0;
			syn_sent_q <= 1'b0;
			fin_sent_q <= 1'b0;
			tact_q     <= 1'b0;
			timer_q    <= '0;
			rcnt_q     <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			acc_q      <= 1'b0;
			n_q        <= '0;
			held_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ISN: isn_q <= cfg_data;
					REG_TIMEOUT: begin
						ito_q <= cfg_data[15:0];
						if (!syn_sent_q) to_q <= {16'd0, cfg_data[15:0]};
					end
					default: ;
				endcase
			end
			if (cmd.latch) begin
				acc_q <= 1'b0;
				n_q   <= '0;
			end
			if (cmd.syn_send) syn_sent_q <= 1'b1;
			if (do_send) begin
				next_q   <= next_q + 64'(seqlen);
				flight_q <= flight_q + seqlen;
				tail_q   <= (tail_q == AW'(PENDING_DEPTH - 1)) ? '0 : tail_q + 1'b1;
				count_q  <= count_q + 1'b1;
				if (snd_fin) fin_sent_q <= 1'b1;
				if (!tact_q) begin
					tact_q  <= 1'b1;
					timer_q <= '0;
				end
			end
			if (cmd.fill_send) n_q <= n_q + 1'b1;
			if (cmd.ack_win) begin
				window_q <= win_in_q;
				acc_q    <= 1'b1;
			end
			if (cmd.ack_adv) acked_q <= cand_q;
			if (cmd.ack_pop) begin
				flight_q <= flight_q - rd_seqlen;
				head_q   <= (head_q == AW'(PENDING_DEPTH - 1)) ? '0 : head_q + 1'b1;
				count_q  <= count_q - 1'b1;
			end
			if (cmd.ack_end) begin
				to_q    <= {16'd0, ito_q};
				timer_q <= '0;
				tact_q  <= (count_q != '0);
				rcnt_q  <= '0;
			end
			if (cmd.tick_add) timer_q <= tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
			if (cmd.tick_fire) begin
				rcnt_q  <= rcnt_inc;
				to_q    <= to_q[31] ? 32'hFFFF_FFFF : {to_q[30:0], 1'b0};
				timer_q <= '0;
			end

			// one held result so the final beat of an event can carry last
			if (cmd.syn_send) begin
				held_q   <= new_res;
				held_v_q <= 1'b1;
			end else if (cmd.probe) begin
				held_q   <= probe_res;
				held_v_q <= 1'b1;
			end else if (cmd.tick_fire) begin
				held_q   <= retx_res;
				held_v_q <= 1'b1;
			end else if (cmd.fill_send) begin
				held_q   <= new_res;
				held_v_q <= 1'b1;
			end else if (cmd.finish) begin
				held_v_q <= 1'b0;
			end

			if (cmd.fill_send && held_v_q) begin
				out_q   <= held_q;
				out_v_q <= 1'b1;
			end else if (cmd.finish) begin
				out_q   <= fin_res;
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_res   = out_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(PENDING_DEPTH)) else $error("queue count exceeds depth");
	a_timer_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> tact_q) else $error("timer idle with segments outstanding");
	a_empty_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (flight_q == '0)) else $error("flight with empty queue");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fill_send && held_v_q) |-> out_free) else $error("output beat overwritten");

endmodule
`default_nettype wire

[sv/tcp_sender_window_retransmit.sv]
// ----------------------------------------------------------------------------
// tcp_sender_window_retransmit
// TCP sender sequence, window and retransmission controller.
// ----------------------------------------------------------------------------
// One event beat is taken at a time; ready returns once its last result beat
// is loaded into the output register. A fill takes a room step and a length
// step per segment and stops when the queue is full, FIN has gone out or the
// result limit is reached. An ack retires segments with one registered queue
// read and one compare per entry, and takes a downward unwrap step when the
// upward one does not apply. Output stalls hold the sequencer until the
// output register is free.
`default_nettype none
module tcp_sender_window_retransmit import tsw_pkg::*; #(
	parameter int MAX_SEGMENT_PAYLOAD = 1452,
	parameter int PENDING_DEPTH       = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// ack_number[31:0], advertised_window[47:32], elapsed_ms[63:48],
	// stream_available[79:64], stream_ended[80], zero pad
	input  wire logic [87:0] s_tdata,
	// operation[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// segment_seqno[31:0], payload_length[42:32], syn_flag[43], fin_flag[44],
	// is_retransmit[45], ack_accepted[46], in_flight_bytes[63:47],
	// retransmit_count[71:64]
	output logic [71:0]      m_tdata,
	// has_segment[0]
	output logic [0:0]       m_tuser,
	output logic             m_tlast
);

	cmd_t cmd;
	sts_t sts;
	res_t res;

	tsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tsw_dp #(
		.MAX_SEGMENT_PAYLOAD (MAX_SEGMENT_PAYLOAD),
		.PENDING_DEPTH       (PENDING_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_op     (s_tuser),
		.in_ack    (s_tdata[31:0]),
		.in_win    (s_tdata[47:32]),
		.in_ms     (s_tdata[63:48]),
		.in_avail  (s_tdata[79:64]),
		.in_ended  (s_tdata[80]),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_res   (res)
	);

	assign m_tdata = {res.rcnt, res.flight, res.acc, res.retx, res.fin, res.syn,
		res.len, res.seqno};
	assign m_tuser = res.has;
	assign m_tlast = res.last;

endmodule
`default_nettype wire
